>>> hdl/gpose_pkg.sv
// ----------------------------------------------------------------------------
// gpose_pkg: shared types and constants for the bone pose compose block
// Field widths, status codes and fixed-point constants.
// ----------------------------------------------------------------------------
package gpose_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = 11;
    localparam int unsigned ACC_W  = 72;
    localparam int unsigned PROD_W = 34;   // one shifted Q2.30 product, unsaturated
    localparam int unsigned CNT_MAX = 2047;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_PAR = 2'd1,
        STATUS_DEPTH   = 2'd2
    } status_t;

    // shift amount codes for the shared multiplier
    typedef enum logic {
        SHIFT_Q30 = 1'b0,
        SHIFT_Q16 = 1'b1
    } shift_t;

    // one multiply-accumulate command
    typedef struct packed {
        logic   clear;  // start new sum
        logic   neg;    // subtract product
        logic   dbl;    // add product twice
        shift_t shift;
    } mac_cmd_t;

endpackage

>>> hdl/global_pose_from_local_pose.sv
// ----------------------------------------------------------------------------
// global_pose_from_local_pose: forward kinematics over a bone hierarchy
// One bone per transfer; composes the local transform with its parent's.
// ----------------------------------------------------------------------------
// Bones arrive in order, one per input transfer; the bone index is an internal
// counter that returns to zero after the transfer marked last_bone. A root
// bone (parent -1), a bad parent (status 1) or a bone past MAX_BONES (status
// 2) passes the local transform through. Any other bone reads its parent's
// global transform from a block of registers-as-RAM (one read port, data
// registered) and runs 38 multiply-accumulate steps on a single 32x32
// multiplier: 10 quaternion products, 9 rotate steps, 16 Hamilton steps and
// 3 scale steps. The nine rotation coefficients are formed by adds on the ten
// products, so the sequencer waits in S_WAIT after the last product before the
// rotate steps, and drains in S_DRAIN after the last step. m_tvalid
// is set in S_OUT, reached from S_READ directly for a pass-through bone and
// through S_RUN, S_WAIT and S_DRAIN for a composed bone. The block takes one
// bone at a time: the next bone is accepted only after the previous output
// has been taken on m_tready. No clearing pass after reset.
module global_pose_from_local_pose #(
    parameter int MAX_BONES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // parent_index[10:0], local_tx, ty, tz, qx, qy, qz, qw, sx, sy, sz; pad to 336
    input  logic [335:0] s_tdata,
    input  logic         s_tlast,   // last_bone
    output logic         m_tvalid,
    input  logic         m_tready,
    // global_tx, ty, tz, qx, qy, qz, qw, sx, sy, sz, bone_status[1:0]; pad to 328
    output logic [327:0] m_tdata,
    output logic         m_tlast    // pose_done
);
    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int W  = gpose_pkg::WORD_W;
    localparam int AC = gpose_pkg::ACC_W;
    localparam int PW = gpose_pkg::PROD_W;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_RUN, S_WAIT, S_DRAIN, S_OUT} state_t;

    state_t state_reg;
    logic [gpose_pkg::IDX_W-1:0] cnt_reg;
    logic [5:0]  step_reg;
    logic [1:0]  drain_reg;
    logic        compose_reg;
    logic        last_reg;
    gpose_pkg::status_t status_reg;
    logic [AW-1:0] widx_reg;
    logic        store_ok_reg;

    // local and working values
    gpose_pkg::word_t lt [3];
    gpose_pkg::word_t lq [4];
    gpose_pkg::word_t ls [3];
    gpose_pkg::word_t pt_reg [3];
    gpose_pkg::word_t pq_reg [4];
    gpose_pkg::word_t ps_reg [3];
    gpose_pkg::word_t lt_reg [3];
    gpose_pkg::word_t lq_reg [4];
    gpose_pkg::word_t ls_reg [3];
    gpose_pkg::prod_t pr_reg [9];  // xx yy zz ww xy xz yz wx wy
    gpose_pkg::prod_t pr_all [10]; // the nine above plus wz straight from the sum
    gpose_pkg::word_t mm_reg [9];
    gpose_pkg::word_t g_reg  [10];

    logic [10*W-1:0] mem [MAX_BONES];
    logic [10*W-1:0] rd_reg;

    logic signed [10:0] par;
    logic          do_acc;
    logic [5:0]    wr_step;
    logic [1:0]    wr_pipe;
    logic          wr_v;
    logic [5:0]    wr_s_reg [2];
    logic          wr_v_reg [2];

    gpose_pkg::mac_cmd_t cmd;
    gpose_pkg::word_t    opa, opb;
    logic signed [AC-1:0] init, acc;

    function automatic gpose_pkg::word_t sat(input logic signed [AC-1:0] v);
        if (v > AC'(64'sh7fffffff)) return 32'sh7fffffff;
        if (v < -AC'(64'sh80000000)) return 32'sh80000000;
        return v[W-1:0];
    endfunction

    assign par = s_tdata[10:0];
    for (genvar i = 0; i < 3; i++) begin : g_l3
        assign lt[i] = s_tdata[11+W*i +: W];
        assign ls[i] = s_tdata[11+W*(7+i) +: W];
    end
    for (genvar i = 0; i < 4; i++) begin : g_l4
        assign lq[i] = s_tdata[11+W*(3+i) +: W];
    end

    // step schedule: 0-9 products, 10-18 rotate (3 per row, row starts from
    // the parent translation), 19-34 Hamilton (4 each), 35-37 scale
    always_comb begin
        cmd  = '{clear: 1'b1, neg: 1'b0, dbl: 1'b0, shift: gpose_pkg::SHIFT_Q30};
        opa  = '0;
        opb  = '0;
        init = '0;
        case (step_reg)
            6'd0:  begin opa = pq_reg[0]; opb = pq_reg[0]; end
            6'd1:  begin opa = pq_reg[1]; opb = pq_reg[1]; end
            6'd2:  begin opa = pq_reg[2]; opb = pq_reg[2]; end
            6'd3:  begin opa = pq_reg[3]; opb = pq_reg[3]; end
            6'd4:  begin opa = pq_reg[0]; opb = pq_reg[1]; end
            6'd5:  begin opa = pq_reg[0]; opb = pq_reg[2]; end
            6'd6:  begin opa = pq_reg[1]; opb = pq_reg[2]; end
            6'd7:  begin opa = pq_reg[3]; opb = pq_reg[0]; end
            6'd8:  begin opa = pq_reg[3]; opb = pq_reg[1]; end
            6'd9:  begin opa = pq_reg[3]; opb = pq_reg[2]; end
            6'd10: begin opa = mm_reg[0]; opb = lt_reg[0]; init = AC'(pt_reg[0]); end
            6'd11: begin opa = mm_reg[1]; opb = lt_reg[1]; cmd.clear = 1'b0; end
            6'd12: begin opa = mm_reg[2]; opb = lt_reg[2]; cmd.clear = 1'b0; end
            6'd13: begin opa = mm_reg[3]; opb = lt_reg[0]; init = AC'(pt_reg[1]); end
            6'd14: begin opa = mm_reg[4]; opb = lt_reg[1]; cmd.clear = 1'b0; end
            6'd15: begin opa = mm_reg[5]; opb = lt_reg[2]; cmd.clear = 1'b0; end
            6'd16: begin opa = mm_reg[6]; opb = lt_reg[0]; init = AC'(pt_reg[2]); end
            6'd17: begin opa = mm_reg[7]; opb = lt_reg[1]; cmd.clear = 1'b0; end
            6'd18: begin opa = mm_reg[8]; opb = lt_reg[2]; cmd.clear = 1'b0; end
            6'd19: begin opa = pq_reg[0]; opb = lq_reg[3]; end
            6'd20: begin opa = pq_reg[3]; opb = lq_reg[0]; cmd.clear = 1'b0; end
            6'd21: begin opa = pq_reg[1]; opb = lq_reg[2]; cmd.clear = 1'b0; end
            6'd22: begin
                opa = pq_reg[2]; opb = lq_reg[1]; cmd.clear = 1'b0; cmd.neg = 1'b1;
            end
            6'd23: begin opa = pq_reg[1]; opb = lq_reg[3]; end
            6'd24: begin opa = pq_reg[3]; opb = lq_reg[1]; cmd.clear = 1'b0; end
            6'd25: begin opa = pq_reg[2]; opb = lq_reg[0]; cmd.clear = 1'b0; end
            6'd26: begin
                opa = pq_reg[0]; opb = lq_reg[2]; cmd.clear = 1'b0; cmd.neg = 1'b1;
            end
            6'd27: begin opa = pq_reg[2]; opb = lq_reg[3]; end
            6'd28: begin opa = pq_reg[3]; opb = lq_reg[2]; cmd.clear = 1'b0; end
            6'd29: begin opa = pq_reg[0]; opb = lq_reg[1]; cmd.clear = 1'b0; end
            6'd30: begin
                opa = pq_reg[1]; opb = lq_reg[0]; cmd.clear = 1'b0; cmd.neg = 1'b1;
            end
            6'd31: begin opa = pq_reg[3]; opb = lq_reg[3]; end
            6'd32: begin
                opa = pq_reg[0]; opb = lq_reg[0]; cmd.clear = 1'b0; cmd.neg = 1'b1;
            end
            6'd33: begin
                opa = pq_reg[1]; opb = lq_reg[1]; cmd.clear = 1'b0; cmd.neg = 1'b1;
            end
            6'd34: begin
                opa = pq_reg[2]; opb = lq_reg[2]; cmd.clear = 1'b0; cmd.neg = 1'b1;
            end
            6'd35: begin
                opa = ps_reg[0]; opb = ls_reg[0]; cmd.shift = gpose_pkg::SHIFT_Q16;
            end
            6'd36: begin
                opa = ps_reg[1]; opb = ls_reg[1]; cmd.shift = gpose_pkg::SHIFT_Q16;
            end
            6'd37: begin
                opa = ps_reg[2]; opb = ls_reg[2]; cmd.shift = gpose_pkg::SHIFT_Q16;
            end
            default: begin end
        endcase
    end

    assign do_acc = (state_reg == S_RUN);

    gpose_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (do_acc),
        .op_cmd   (cmd),
        .op_a     (opa),
        .op_b     (opb),
        .acc_init (init),
        .acc      (acc)
    );

    // accumulator result lands after the MAC's product and accumulator registers
    assign wr_step = wr_s_reg[1];
    assign wr_v    = wr_v_reg[1];
    assign wr_pipe = '0;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            pr_all[i] = pr_reg[i];
        end
        pr_all[9] = acc[PW-1:0];
    end

    // matrix coefficients from the ten products (combinational adds at accumulator width)
    function automatic gpose_pkg::word_t msum(input int k,
                                              input gpose_pkg::prod_t p [10]);
        logic signed [AC-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, r;
        xx = AC'(p[0]); yy = AC'(p[1]); zz = AC'(p[2]); ww = AC'(p[3]);
        xy = AC'(p[4]); xz = AC'(p[5]); yz = AC'(p[6]);
        wx = AC'(p[7]); wy = AC'(p[8]); wz = AC'(p[9]);
        case (k)
            0: r = xx + ww - yy - zz;
            1: r = 2 * xy - 2 * wz;
            2: r = 2 * xz + 2 * wy;
            3: r = 2 * wz + 2 * xy;
            4: r = ww - xx + yy - zz;
            5: r = 2 * yz - 2 * wx;
            6: r = 2 * xz - 2 * wy;
            7: r = 2 * wx + 2 * yz;
            default: r = ww - xx - yy + zz;
        endcase
        return sat(r);
    endfunction

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            m_tvalid  <= 1'b0;
            wr_v_reg[0] <= 1'b0;
            wr_v_reg[1] <= 1'b0;
        end else begin
            wr_v_reg[0] <= do_acc;
            wr_v_reg[1] <= wr_v_reg[0];
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        last_reg <= s_tlast;
                        for (int i = 0; i < 3; i++) begin
                            lt_reg[i] <= lt[i]; ls_reg[i] <= ls[i];
                            g_reg[i] <= lt[i]; g_reg[7+i] <= ls[i];
                        end
                        for (int i = 0; i < 4; i++) begin
                            lq_reg[i] <= lq[i]; g_reg[3+i] <= lq[i];
                        end
                        widx_reg     <= cnt_reg[AW-1:0];
                        store_ok_reg <= (32'(cnt_reg) < 32'(MAX_BONES));
                        compose_reg  <= 1'b0;
                        if (32'(cnt_reg) >= 32'(MAX_BONES)) begin
                            status_reg <= gpose_pkg::STATUS_DEPTH;
                        end else if (par == -11'sd1) begin
                            status_reg <= gpose_pkg::STATUS_OK;
                        end else if (par < 0 || $unsigned(par) >= cnt_reg) begin
                            status_reg <= gpose_pkg::STATUS_BAD_PAR;
                        end else begin
                            status_reg  <= gpose_pkg::STATUS_OK;
                            compose_reg <= 1'b1;
                        end
                        rd_reg <= mem[par[AW-1:0]];
                        if (s_tlast) begin
                            cnt_reg <= '0;
                        end else if (cnt_reg != gpose_pkg::IDX_W'(gpose_pkg::CNT_MAX)) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    for (int i = 0; i < 3; i++) begin
                        pt_reg[i] <= rd_reg[W*i +: W];
                        ps_reg[i] <= rd_reg[W*(7+i) +: W];
                    end
                    for (int i = 0; i < 4; i++) begin
                        pq_reg[i] <= rd_reg[W*(3+i) +: W];
                    end
                    step_reg  <= '0;
                    state_reg <= compose_reg ? S_RUN : S_OUT;
                end
                S_RUN: begin
                    if (step_reg == 6'd9) begin
                        // coefficients land in mm_reg once the last product leaves the accumulator
                        step_reg  <= 6'd10;
                        drain_reg <= '0;
                        state_reg <= S_WAIT;
                    end else if (step_reg == 6'd37) begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_WAIT: begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd1) begin
                        state_reg <= S_RUN;
                    end
                end
                S_DRAIN: begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd2) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                        if (store_ok_reg) begin
                            mem[widx_reg] <= {g_reg[9], g_reg[8], g_reg[7], g_reg[6],
                                g_reg[5], g_reg[4], g_reg[3], g_reg[2], g_reg[1], g_reg[0]};
                        end
                    end else if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // capture accumulator results
            if (wr_v) begin
                case (wr_step)
                    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8: begin
                        pr_reg[wr_step[3:0]] <= acc[PW-1:0];
                    end
                    6'd9: begin
                        for (int k = 0; k < 9; k++) begin
                            mm_reg[k] <= msum(k, pr_all);
                        end
                    end
                    6'd12: g_reg[0] <= sat(acc);
                    6'd15: g_reg[1] <= sat(acc);
                    6'd18: g_reg[2] <= sat(acc);
                    6'd22: g_reg[3] <= sat(acc);
                    6'd26: g_reg[4] <= sat(acc);
                    6'd30: g_reg[5] <= sat(acc);
                    6'd34: g_reg[6] <= sat(acc);
                    6'd35: g_reg[7] <= sat(acc);
                    6'd36: g_reg[8] <= sat(acc);
                    6'd37: g_reg[9] <= sat(acc);
                    default: begin end
                endcase
            end
        end
        wr_s_reg[0] <= step_reg + 6'(wr_pipe);
        wr_s_reg[1] <= wr_s_reg[0];
    end

    assign m_tdata = {6'd0, status_reg, g_reg[9], g_reg[8], g_reg[7], g_reg[6],
                      g_reg[5], g_reg[4], g_reg[3], g_reg[2], g_reg[1], g_reg[0]};
    assign m_tlast = last_reg;
endmodule

>>> hdl/gpose_mac.sv
// ----------------------------------------------------------------------------
// gpose_mac: shared 32x32 multiply-accumulate unit
// Registered product, floor shift, then accumulate into a wide sum.
// ----------------------------------------------------------------------------
module gpose_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                op_valid,
    input  gpose_pkg::mac_cmd_t op_cmd,
    input  gpose_pkg::word_t    op_a,
    input  gpose_pkg::word_t    op_b,
    input  logic signed [gpose_pkg::ACC_W-1:0] acc_init,
    output logic signed [gpose_pkg::ACC_W-1:0] acc
);
    logic signed [63:0]         prod_reg;
    logic                       pvalid_reg;
    gpose_pkg::mac_cmd_t        pcmd_reg;
    logic signed [gpose_pkg::ACC_W-1:0] pinit_reg;
    logic signed [gpose_pkg::ACC_W-1:0] acc_reg;
    logic signed [gpose_pkg::ACC_W-1:0] term;
    logic signed [gpose_pkg::ACC_W-1:0] base;

    always_comb begin
        if (pcmd_reg.shift == gpose_pkg::SHIFT_Q16) begin
            term = gpose_pkg::ACC_W'(prod_reg >>> 16);
        end else begin
            term = gpose_pkg::ACC_W'(prod_reg >>> 30);
        end
        if (pcmd_reg.dbl) begin
            term = term <<< 1;
        end
        if (pcmd_reg.neg) begin
            term = -term;
        end
        base = pcmd_reg.clear ? pinit_reg : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
        end else begin
            pvalid_reg <= op_valid;
        end
        prod_reg  <= op_a * op_b;
        pcmd_reg  <= op_cmd;
        pinit_reg <= acc_init;
        if (pvalid_reg) begin
            acc_reg <= base + term;
        end
    end

    assign acc = acc_reg;
endmodule
